[rtl/cdc_pkg.sv]
// ----------------------------------------------------------------------------
// cdc_pkg
// Shared types, constants and helpers of the causal depthwise conv1d filter.
// ----------------------------------------------------------------------------
package cdc_pkg;

   // fixed field widths
   localparam int unsigned SAMPLE_W  = 16;
   localparam int unsigned PROD_W    = 2 * SAMPLE_W;
   localparam int unsigned FRAC_W    = 12;
   localparam int unsigned MAX_LANES = 4;
   localparam int unsigned MAX_TAPS  = 4;
   localparam int unsigned NUM_REGS  = 4;
   localparam int unsigned CSR_IDX_W = 3;

   // parameter defaults
   localparam int unsigned DEF_TAPS  = 4;
   localparam int unsigned DEF_LANES = 4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TAP_0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TAP_1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TAP_2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TAP_3 = 3'd3;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef sample_type [NUM_REGS-1:0]  tap_set_type;
   typedef sample_type [MAX_LANES-1:0] lane_vec_type;

   typedef struct packed {
      logic       first;
      sample_type sample_lane0;
      sample_type sample_lane1;
      sample_type sample_lane2;
      sample_type sample_lane3;
   } req_payload_type;

   typedef struct packed {
      sample_type filtered_lane0;
      sample_type filtered_lane1;
      sample_type filtered_lane2;
      sample_type filtered_lane3;
   } rsp_payload_type;

   // control handed from the pipeline control to every lane
   typedef struct packed {
      logic accept;
      logic first;
   } lane_ctrl_type;

   // pick one lane's sample out of an input transfer
   function automatic sample_type req_sample(req_payload_type p, int unsigned idx);
      sample_type s;
      case (idx)
         0:       s = p.sample_lane0;
         1:       s = p.sample_lane1;
         2:       s = p.sample_lane2;
         default: s = p.sample_lane3;
      endcase
      return s;
   endfunction

   // place lane results into the result struct
   function automatic rsp_payload_type pack_rsp(lane_vec_type v);
      rsp_payload_type r;
      r.filtered_lane0 = v[0];
      r.filtered_lane1 = v[1];
      r.filtered_lane2 = v[2];
      r.filtered_lane3 = v[3];
      return r;
   endfunction

endpackage

[rtl/cdc_lane.sv]
// ----------------------------------------------------------------------------
// cdc_lane
// One filter lane: sample history, registered tap products, then the sum
// truncated to Q4.12 and saturated to 16 bits.
// ----------------------------------------------------------------------------
module cdc_lane
   import cdc_pkg::*;
#(
   parameter int unsigned TAPS = DEF_TAPS
) (
   input  logic          clock,
   input  logic          reset,
   input  lane_ctrl_type ctrl,
   input  sample_type    sample,
   input  tap_set_type   taps,
   output sample_type    result
);

   localparam int unsigned HIST_D = TAPS - 1;
   localparam int unsigned SUM_W  = PROD_W + $clog2(TAPS);
   localparam int unsigned Q_W    = SUM_W - FRAC_W;
   localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(32767);
   localparam logic signed [Q_W-1:0] Q_MIN = -(Q_W'(32768));

   sample_type                     hist_ff [HIST_D];
   sample_type                     hist_in [HIST_D];
   sample_type                     hist_eff [HIST_D];
   logic signed [PROD_W-1:0]       prod_ff [TAPS];
   logic signed [PROD_W-1:0]       prod_in [TAPS];
   logic signed [SUM_W-1:0]        sum;
   logic signed [Q_W-1:0]          quot;

   // clear the history view at the start of a sequence
   always_comb begin
      for (int j = 0; j < HIST_D; j++) begin
         hist_eff[j] = ctrl.first ? '0 : hist_ff[j];
      end
   end

   // shift the current sample in, newest first
   always_comb begin
      hist_in = hist_ff;
      if (ctrl.accept) begin
         for (int j = HIST_D - 1; j > 0; j--) begin
            hist_in[j] = hist_eff[j-1];
         end
         hist_in[0] = sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < HIST_D; j++) begin
            hist_ff[j] <= '0;
         end
      end else begin
         hist_ff <= hist_in;
      end
   end

   // form one product per tap
   always_comb begin
      for (int j = 0; j < HIST_D; j++) begin
         prod_in[j] = taps[j] * hist_eff[j];
      end
      prod_in[TAPS-1] = taps[TAPS-1] * sample;
   end

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         prod_ff <= prod_in;
      end
   end

   // sum exactly, drop the fraction, saturate
   always_comb begin
      sum = '0;
      for (int j = 0; j < TAPS; j++) begin
         sum = sum + SUM_W'(prod_ff[j]);
      end
      quot = sum[SUM_W-1:FRAC_W];
      if (quot > Q_MAX) begin
         result = sample_type'(Q_MAX);
      end else if (quot < Q_MIN) begin
         result = sample_type'(Q_MIN);
      end else begin
         result = quot[SAMPLE_W-1:0];
      end
   end

endmodule

[rtl/cdc_merge.sv]
// ----------------------------------------------------------------------------
// cdc_merge
// Output register: gathers the lane results into one result transfer and
// zeroes the lanes that are not built.
// ----------------------------------------------------------------------------
module cdc_merge
   import cdc_pkg::*;
#(
   parameter int unsigned LANES = DEF_LANES
) (
   input  logic            clock,
   input  logic            load,
   input  sample_type      lane_result [LANES],
   output rsp_payload_type rsp_data
);

   lane_vec_type    merged;
   rsp_payload_type rsp_data_ff;
   rsp_payload_type rsp_data_in;

   // fill unused lanes with zero
   for (genvar l = 0; l < MAX_LANES; l++) begin : g_fill
      if (l < LANES) begin : g_used
         assign merged[l] = lane_result[l];
      end else begin : g_unused
         assign merged[l] = '0;
      end
   end

   // hold the result until it is taken
   always_comb begin
      rsp_data_in = load ? pack_rsp(merged) : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_data = rsp_data_ff;

endmodule

[rtl/causal_depthwise_conv1d.sv]
// ----------------------------------------------------------------------------
// causal_depthwise_conv1d
// Four-lane causal depthwise FIR over Q4.12 samples with configurable taps.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall  req_payload_type
//   rsp      out        rsp_valid/rsp_stall  rsp_payload_type
//   csr      in         csr_we               csr_index, csr_wdata
//
// One item per cycle sustained while the result side does not stall; the result
// passes the product register, then the output register, before it is valid
// and can transfer.
// Each lane has its own multipliers, one per tap, so all lanes run at once.
// Reset is synchronous: taps and history clear to zero, pipeline empties.
// A stalled result holds in the output register while the product stage
// still takes one more item; input stalls only when both stages are full.
// ----------------------------------------------------------------------------
module causal_depthwise_conv1d
   import cdc_pkg::*;
#(
   parameter int unsigned TAPS  = DEF_TAPS,
   parameter int unsigned LANES = DEF_LANES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_payload_type      req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_payload_type      rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  sample_type           csr_wdata
);

   tap_set_type   taps_ff;
   tap_set_type   taps_in;
   logic          prod_valid_ff;
   logic          prod_valid_in;
   logic          out_valid_ff;
   logic          out_valid_in;
   logic          out_ready;
   logic          prod_ready;
   logic          advance;
   lane_ctrl_type lane_ctrl;
   sample_type    lane_result [LANES];

   // decode register writes
   always_comb begin
      taps_in = taps_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_TAP_0: taps_in[0] = csr_wdata;
            CSR_TAP_1: taps_in[1] = csr_wdata;
            CSR_TAP_2: taps_in[2] = csr_wdata;
            CSR_TAP_3: taps_in[3] = csr_wdata;
            default:   taps_in = taps_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         taps_ff <= '0;
      end else begin
         taps_ff <= taps_in;
      end
   end

   // pipeline control: each stage moves on when the next one has room
   always_comb begin
      out_ready       = !out_valid_ff || !rsp_stall;
      prod_ready      = !prod_valid_ff || out_ready;
      advance         = prod_valid_ff && out_ready;
      lane_ctrl.accept = req_valid && prod_ready;
      lane_ctrl.first  = req_data.first;
      prod_valid_in   = lane_ctrl.accept ? 1'b1 : (advance ? 1'b0 : prod_valid_ff);
      out_valid_in    = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   assign req_stall = !prod_ready;
   assign rsp_valid = out_valid_ff;

   // one filter lane per sample
   for (genvar l = 0; l < LANES; l++) begin : g_lane
      cdc_lane #(
         .TAPS (TAPS)
      ) u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (lane_ctrl),
         .sample (req_sample(req_data, l)),
         .taps   (taps_ff),
         .result (lane_result[l])
      );
   end

   // gather lane results into the output register
   cdc_merge #(
      .LANES (LANES)
   ) u_merge (
      .clock       (clock),
      .load        (advance),
      .lane_result (lane_result),
      .rsp_data    (rsp_data)
   );

`ifndef NO_ASSERTIONS
   // input stalls only while the product stage is occupied
   a_stall_needs_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> prod_valid_ff)
      else $error("input stalled with an empty product stage");

   // an accepted transfer lands in the product stage
   a_accept_fills : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> prod_valid_ff)
      else $error("accepted transfer lost before the product stage");

   // a waiting product moves into an empty output register
   a_prod_to_out : assert property (@(posedge clock) disable iff (reset)
      (prod_valid_ff && !out_valid_ff) |=> out_valid_ff)
      else $error("product stage did not advance into empty output");
`endif

endmodule

[bench/cdc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdc_checker
// Watches the request, result and register ports of the conv1d filter. It
// keeps its own copy of the taps and the per-lane sample history, works out
// the filtered vector for every request transfer, and compares each result
// transfer, lane by lane, against the oldest vector still owed.
// ----------------------------------------------------------------------------
module cdc_checker
   import cdc_pkg::*;
#(
   parameter int unsigned TAPS  = DEF_TAPS,
   parameter int unsigned LANES = DEF_LANES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  req_payload_type      req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  rsp_payload_type      rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  sample_type           csr_wdata,
   output int unsigned          fail_count,
   output int unsigned          pending,
   output int unsigned          compared
);

   // four Q8.24 products plus headroom
   localparam int unsigned ACC_W        = PROD_W + 4;
   localparam int unsigned REPORT_LIMIT = 10;

   sample_type      tap_weight [NUM_REGS];
   sample_type      lane_hist  [TAPS-1][MAX_LANES];
   rsp_payload_type filtered_q [$];

   // filter one request vector and shift its samples into the history
   function automatic rsp_payload_type filter_vector(req_payload_type p);
      sample_type              lane_in [MAX_LANES];
      sample_type              y       [MAX_LANES];
      logic signed [ACC_W-1:0] acc;
      logic signed [ACC_W-1:0] prod;
      rsp_payload_type         r;
      lane_in[0] = p.sample_lane0;
      lane_in[1] = p.sample_lane1;
      lane_in[2] = p.sample_lane2;
      lane_in[3] = p.sample_lane3;
      // a new sequence starts from an empty history
      if (p.first) begin
         for (int j = 0; j < TAPS - 1; j++)
            for (int l = 0; l < MAX_LANES; l++)
               lane_hist[j][l] = '0;
      end
      for (int l = 0; l < MAX_LANES; l++) begin
         y[l] = '0;
         if (l < LANES) begin
            prod = tap_weight[TAPS-1] * lane_in[l];
            acc  = prod;
            for (int j = 0; j < TAPS - 1; j++) begin
               prod = tap_weight[j] * lane_hist[j][l];
               acc  = acc + prod;
            end
            // floor to Q4.12, then clamp to 16 bits
            acc = acc >>> FRAC_W;
            if (acc > 32767)
               y[l] = 16'sh7fff;
            else if (acc < -32768)
               y[l] = 16'sh8000;
            else
               y[l] = acc[SAMPLE_W-1:0];
            for (int j = TAPS - 2; j > 0; j--)
               lane_hist[j][l] = lane_hist[j-1][l];
            lane_hist[0][l] = lane_in[l];
         end
      end
      r.filtered_lane0 = y[0];
      r.filtered_lane1 = y[1];
      r.filtered_lane2 = y[2];
      r.filtered_lane3 = y[3];
      return r;
   endfunction

   // track registers and requests, compare results
   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++)
            tap_weight[i] = '0;
         for (int j = 0; j < TAPS - 1; j++)
            for (int l = 0; l < MAX_LANES; l++)
               lane_hist[j][l] = '0;
         filtered_q.delete();
      end else begin
         // writes past the last tap are dropped
         if (csr_we && csr_index <= CSR_TAP_3)
            tap_weight[csr_index] = csr_wdata;
         if (req_valid && !req_stall)
            filtered_q.push_back(filter_vector(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (filtered_q.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("%0t: unexpected result transfer %h %h %h %h", $realtime,
                           rsp_data.filtered_lane0, rsp_data.filtered_lane1,
                           rsp_data.filtered_lane2, rsp_data.filtered_lane3);
            end else begin
               want = filtered_q.pop_front();
               compared++;
               if (rsp_data.filtered_lane0 !== want.filtered_lane0 ||
                   rsp_data.filtered_lane1 !== want.filtered_lane1 ||
                   rsp_data.filtered_lane2 !== want.filtered_lane2 ||
                   rsp_data.filtered_lane3 !== want.filtered_lane3) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT)
                     $display("%0t: result %0d mismatch, expected %h %h %h %h, got %h %h %h %h",
                              $realtime, compared,
                              want.filtered_lane0, want.filtered_lane1,
                              want.filtered_lane2, want.filtered_lane3,
                              rsp_data.filtered_lane0, rsp_data.filtered_lane1,
                              rsp_data.filtered_lane2, rsp_data.filtered_lane3);
               end
            end
         end
      end
      pending = filtered_q.size();
   end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the conv1d filter with directed vectors at the sample and tap
// extremes, then with random sequences under several tap settings, while
// both ports pause at random. The checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module tb_top;
   import cdc_pkg::*;

   localparam int unsigned TAPS            = DEF_TAPS;
   localparam int unsigned LANES           = DEF_LANES;
   localparam int unsigned RAND_PHASES     = 8;
   localparam int unsigned ITEMS_PER_PHASE = 172;
   localparam int unsigned STEADY_PHASE    = 5;
   localparam int unsigned SETTLE_CYCLES   = 4;
   localparam int unsigned CYCLE_LIMIT     = 400000;

   // first register index with no tap behind it
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = CSR_TAP_3 + 1'b1;

   localparam sample_type Q_MAX     = 16'sh7fff;
   localparam sample_type Q_MIN     = 16'sh8000;
   localparam sample_type Q_ONE     = 16'sh1000;
   localparam sample_type Q_NEG_ONE = 16'shf000;
   localparam sample_type Q_HALF    = 16'sh0800;

   // tap setting styles
   localparam int unsigned TAPS_SMALL   = 0;
   localparam int unsigned TAPS_FULL    = 1;
   localparam int unsigned TAPS_EXTREME = 2;
   localparam int unsigned TAPS_PASS    = 3;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_payload_type      req_data;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_payload_type      rsp_data;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   sample_type           csr_wdata;
   logic                 steady;

   int unsigned fail_count;
   int unsigned pending;
   int unsigned compared;
   int unsigned cycle_count = 0;
   int unsigned sent_count;
   int unsigned seq_count;
   int unsigned setting_count;

   causal_depthwise_conv1d #(.TAPS(TAPS), .LANES(LANES)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   cdc_checker #(.TAPS(TAPS), .LANES(LANES)) checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending),
      .compared   (compared)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // idle length: mostly none or short, now and then long
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (steady)
         return 0;
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic sample_type rand_between(int lo, int hi);
      return sample_type'(lo + int'($urandom_range(0, hi - lo)));
   endfunction

   function automatic sample_type pick_sample();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 4)
         return sample_type'($urandom);
      if (r < 8)
         return rand_between(-4096, 4096);
      if (r == 8)
         return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
      return rand_between(-1, 1);
   endfunction

   function automatic sample_type pick_tap(int unsigned style);
      case (style)
         TAPS_FULL:
            return sample_type'($urandom);
         TAPS_EXTREME:
            case ($urandom_range(0, 4))
               0:       return Q_MAX;
               1:       return Q_MIN;
               2:       return '0;
               3:       return Q_ONE;
               default: return Q_NEG_ONE;
            endcase
         default:
            return rand_between(-4096, 4096);
      endcase
   endfunction

   function automatic req_payload_type mk_item(logic first, sample_type a, sample_type b,
                                               sample_type c, sample_type d);
      req_payload_type p;
      p.first        = first;
      p.sample_lane0 = a;
      p.sample_lane1 = b;
      p.sample_lane2 = c;
      p.sample_lane3 = d;
      return p;
   endfunction

   // offer one vector and hold it until the transfer
   task automatic send_sample(input req_payload_type p);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sent_count++;
      if (p.first)
         seq_count++;
      @(negedge clock);
   endtask

   // hold off until every owed result has come, then let the pipe empty
   task automatic settle();
      req_valid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input sample_type value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic load_taps(input sample_type t0, input sample_type t1,
                            input sample_type t2, input sample_type t3);
      csr_write(CSR_TAP_0, t0);
      csr_write(CSR_TAP_1, t1);
      csr_write(CSR_TAP_2, t2);
      csr_write(CSR_TAP_3, t3);
      setting_count++;
   endtask

   // result side: random stall bursts unless in a steady stretch
   initial begin
      int unsigned run_len;
      rsp_stall <= 1'b0;
      @(negedge clock);
      forever begin
         if (steady) begin
            rsp_stall <= 1'b0;
            @(negedge clock);
         end else begin
            run_len = pick_gap();
            if (run_len != 0) begin
               rsp_stall <= 1'b1;
               repeat (run_len) @(negedge clock);
            end
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
   end

   // stimulus
   initial begin
      req_payload_type item;
      int unsigned     seq_len;
      int unsigned     in_phase;
      int unsigned     style;
      sample_type      t3;
      sent_count    = 0;
      seq_count     = 0;
      setting_count = 0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= CSR_TAP_0;
      csr_wdata <= '0;
      steady    <= 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // taps out of reset are zero, so everything filters to zero
      send_sample(mk_item(1'b1, Q_MAX, Q_MIN, 16'sh0001, 16'shffff));
      send_sample(mk_item(1'b0, 16'sh1234, Q_MIN, Q_MAX, Q_ONE));

      // mixed taps, then writes to unmapped indexes that must change nothing
      settle();
      load_taps(Q_MIN, Q_MAX, Q_HALF, Q_ONE);
      csr_write(CSR_UNMAPPED, Q_MAX);
      csr_write({CSR_IDX_W{1'b1}}, Q_MIN);
      send_sample(mk_item(1'b1, Q_MAX, Q_MIN, Q_ONE, 16'sh0000));
      send_sample(mk_item(1'b0, Q_MIN, Q_MAX, Q_NEG_ONE, 16'sh0001));
      send_sample(mk_item(1'b0, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000));
      send_sample(mk_item(1'b0, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000));
      send_sample(mk_item(1'b0, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000));
      // restart mid-stream: history must clear
      send_sample(mk_item(1'b1, Q_ONE, Q_ONE, Q_ONE, Q_ONE));
      send_sample(mk_item(1'b0, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
      send_sample(mk_item(1'b0, Q_MAX, Q_MAX, Q_MAX, Q_MAX));

      // most negative taps drive the positive saturation limit
      settle();
      load_taps(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
      send_sample(mk_item(1'b1, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
      send_sample(mk_item(1'b0, Q_MAX, Q_MIN, Q_MAX, Q_MIN));
      send_sample(mk_item(1'b0, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
      send_sample(mk_item(1'b0, 16'shffff, 16'sh0001, 16'sh0000, Q_MAX));

      // most positive taps
      settle();
      load_taps(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
      send_sample(mk_item(1'b1, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
      send_sample(mk_item(1'b0, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
      send_sample(mk_item(1'b0, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
      send_sample(mk_item(1'b0, Q_MIN, Q_MIN, Q_MIN, Q_MIN));

      // random sequences, a fresh tap setting per phase
      for (int unsigned phase = 0; phase < RAND_PHASES; phase++) begin
         settle();
         steady <= (phase == STEADY_PHASE);
         style = phase % 4;
         t3 = (style == TAPS_PASS) ? Q_ONE : pick_tap(style);
         load_taps(pick_tap(style), pick_tap(style), pick_tap(style), t3);
         if ($urandom_range(0, 1))
            csr_write(CSR_IDX_W'($urandom_range(CSR_UNMAPPED, (1 << CSR_IDX_W) - 1)),
                      sample_type'($urandom));
         in_phase = 0;
         while (in_phase < ITEMS_PER_PHASE) begin
            seq_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 24);
            for (int unsigned k = 0; k < seq_len && in_phase < ITEMS_PER_PHASE; k++) begin
               // a stray restart now and then inside a sequence
               item = mk_item((k == 0) || ($urandom_range(0, 19) == 0), pick_sample(),
                              pick_sample(), pick_sample(), pick_sample());
               send_sample(item);
               in_phase++;
            end
            if ($urandom_range(0, 11) == 0)
               settle();
         end
      end

      steady <= 1'b0;
      settle();
      $display("Sent %0d vectors in %0d sequences over %0d tap settings", sent_count,
               seq_count, setting_count);
      $display("Compared %0d filtered vectors, %0d failures", compared, fail_count);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
